FILE: rtl/rras_pkg.sv
package rras_pkg;

   localparam int unsigned POS_W      = 21;
   localparam int unsigned LEN_W      = 16;
   localparam int unsigned LOST_W     = 32;
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned LIM_W      = 19;
   localparam int unsigned SIZE_W     = LEN_W + 1;
   localparam int unsigned SUM_W      = POS_W + 2;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam int unsigned ALIGN_BYTES   = 32;
   localparam int unsigned HEADER_BYTES  = 32;
   localparam int unsigned ALIGN_LOG2    = $clog2(ALIGN_BYTES);
   localparam int unsigned CLAMP_DIVISOR = 5;

   localparam int unsigned RING_RESET = 307200;
   localparam int unsigned CAP_RESET  = (RING_RESET / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int unsigned LIM_RESET  = CAP_RESET / CLAMP_DIVISOR;

   // floor(x / 5) as (x * DIV_MULT) >> DIV_SHIFT, exact for x below 2**22
   localparam int unsigned DIV_SHIFT = 23;
   localparam int unsigned DIV_MULT  = ((2 ** DIV_SHIFT) + CLAMP_DIVISOR - 1) / CLAMP_DIVISOR;

   localparam logic [CMD_W-1:0] CMD_RESERVE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ_LOST = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] ADDR_RING_BYTES = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_CONTIGUOUS = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [LEN_W-1:0] payload_len;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    record_offset;
      logic [LEN_W-1:0]    stored_len;
      logic                filler_written;
      logic [POS_W-1:0]    filler_offset;
      logic [POS_W-1:0]    filler_payload_len;
      logic [POS_W-1:0]    bytes_used;
      logic [POS_W-1:0]    write_offset;
      logic [POS_W-1:0]    read_offset;
      logic [LOST_W-1:0]   lost_count;
      logic                empty_res;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0] cap;
      logic [LIM_W-1:0] lim;
      logic             contiguous;
      logic             clear;
   } cfg_type;

endpackage

FILE: rtl/rras_csr.sv
module rras_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rras_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rras_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rras_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output rras_pkg::cfg_type                   cfg
);

   logic [rras_pkg::POS_W-1:0]   ring_ff;
   logic [rras_pkg::POS_W-1:0]   ring_in;
   logic [rras_pkg::POS_W-1:0]   cap_ff;
   logic [rras_pkg::POS_W-1:0]   cap_in;
   logic [rras_pkg::LIM_W-1:0]   lim_ff;
   logic [rras_pkg::LIM_W-1:0]   lim_in;
   logic                         contig_ff;
   logic                         contig_in;
   logic                         wr_en;
   logic                         wr_ring;
   logic                         wr_contig;
   logic [rras_pkg::POS_W-1:0]   wr_cap;
   logic [2*rras_pkg::POS_W-1:0] prod;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wr_ring    = wr_en && (csr_paddr[2] == rras_pkg::ADDR_RING_BYTES[2]);
   assign wr_contig  = wr_en && (csr_paddr[2] == rras_pkg::ADDR_CONTIGUOUS[2]);

   // rounded capacity and its fifth, worked out on the write
   assign wr_cap = {csr_pwdata[rras_pkg::POS_W-1:rras_pkg::ALIGN_LOG2],
                    {rras_pkg::ALIGN_LOG2{1'b0}}};
   assign prod   = wr_cap * rras_pkg::POS_W'(rras_pkg::DIV_MULT);

   always_comb begin
      ring_in   = ring_ff;
      cap_in    = cap_ff;
      lim_in    = lim_ff;
      contig_in = contig_ff;
      if (wr_ring) begin
         ring_in = csr_pwdata[rras_pkg::POS_W-1:0];
         cap_in  = wr_cap;
         lim_in  = prod[rras_pkg::DIV_SHIFT +: rras_pkg::LIM_W];
      end
      if (wr_contig) begin
         contig_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff   <= rras_pkg::POS_W'(rras_pkg::RING_RESET);
         cap_ff    <= rras_pkg::POS_W'(rras_pkg::CAP_RESET);
         lim_ff    <= rras_pkg::LIM_W'(rras_pkg::LIM_RESET);
         contig_ff <= 1'b0;
      end else begin
         ring_ff   <= ring_in;
         cap_ff    <= cap_in;
         lim_ff    <= lim_in;
         contig_ff <= contig_in;
      end
   end

   always_comb begin
      if (csr_paddr[2] == rras_pkg::ADDR_CONTIGUOUS[2]) begin
         csr_prdata = {{(rras_pkg::CSR_DATA_W-1){1'b0}}, contig_ff};
      end else begin
         csr_prdata = {{(rras_pkg::CSR_DATA_W-rras_pkg::POS_W){1'b0}}, ring_ff};
      end
   end

   assign cfg.cap        = cap_ff;
   assign cfg.lim        = lim_ff;
   assign cfg.contiguous = contig_ff;
   assign cfg.clear      = wr_ring;

endmodule

FILE: rtl/rras_engine.sv
module rras_engine (
   input  logic              clock,
   input  logic              reset,
   input  rras_pkg::cfg_type cfg,
   input  logic              fire,
   input  rras_pkg::req_type item,
   output rras_pkg::rsp_type result
);

   localparam int unsigned POS_W  = rras_pkg::POS_W;
   localparam int unsigned SIZE_W = rras_pkg::SIZE_W;
   localparam int unsigned SUM_W  = rras_pkg::SUM_W;
   localparam int unsigned LEN_W  = rras_pkg::LEN_W;
   localparam int unsigned LOST_W = rras_pkg::LOST_W;
   localparam int unsigned AL     = rras_pkg::ALIGN_LOG2;

   logic [POS_W-1:0]  write_pos_ff, write_pos_in;
   logic [POS_W-1:0]  read_pos_ff, read_pos_in;
   logic [POS_W-1:0]  used_ff, used_in;
   logic [LOST_W-1:0] lost_ff, lost_in;

   logic [LEN_W-1:0]  clamped;
   logic [SIZE_W-1:0] res_size;
   logic [SIZE_W-1:0] rel_size;
   logic [SUM_W-1:0]  used_plus;
   logic [SUM_W-1:0]  wpos_plus;
   logic [POS_W-1:0]  fill;
   logic [SUM_W-1:0]  used_fill;
   logic [POS_W-1:0]  wpos_wrap;
   logic [POS_W-1:0]  rpos_wrap;

   function automatic logic [SIZE_W-1:0] record_size(input logic [LEN_W-1:0] len);
      logic [SIZE_W-1:0] t;
      t = {1'b0, len} + SIZE_W'(rras_pkg::HEADER_BYTES + rras_pkg::ALIGN_BYTES - 1);
      return {t[SIZE_W-1:AL], {AL{1'b0}}};
   endfunction

   function automatic logic [POS_W-1:0] wrap_add(input logic [POS_W-1:0] pos,
                                                 input logic [SIZE_W-1:0] add,
                                                 input logic [POS_W-1:0] cap);
      logic [POS_W:0] s;
      s = {1'b0, pos} + (POS_W+1)'(add);
      if (s >= {1'b0, cap}) begin
         s = s - {1'b0, cap};
      end
      if (s >= {1'b0, cap}) begin
         s = '0;
      end
      return s[POS_W-1:0];
   endfunction

   assign clamped   = ({3'b0, item.payload_len} >= cfg.lim) ? cfg.lim[LEN_W-1:0]
                                                           : item.payload_len;
   assign res_size  = record_size(clamped);
   assign rel_size  = record_size(item.payload_len);
   assign used_plus = SUM_W'(used_ff) + SUM_W'(res_size);
   assign wpos_plus = SUM_W'(write_pos_ff) + SUM_W'(res_size);
   assign fill      = cfg.cap - write_pos_ff;
   assign used_fill = used_plus + SUM_W'(fill);
   assign wpos_wrap = wrap_add(write_pos_ff, res_size, cfg.cap);
   assign rpos_wrap = wrap_add(read_pos_ff, rel_size, cfg.cap);

   always_comb begin
      write_pos_in = write_pos_ff;
      read_pos_in  = read_pos_ff;
      used_in      = used_ff;
      lost_in      = lost_ff;
      result       = '0;
      result.lost_count = lost_ff;
      unique case (item.command)
         rras_pkg::CMD_RESERVE: begin
            result.stored_len = clamped;
            if (used_plus <= SUM_W'(cfg.cap) &&
                (!cfg.contiguous || wpos_plus <= SUM_W'(cfg.cap))) begin
               result.record_offset = write_pos_ff;
               used_in              = used_plus[POS_W-1:0];
               write_pos_in         = wpos_wrap;
            end else if (used_plus <= SUM_W'(cfg.cap) && used_fill <= SUM_W'(cfg.cap)) begin
               result.filler_written     = 1'b1;
               result.filler_offset      = write_pos_ff;
               result.filler_payload_len = (fill > POS_W'(rras_pkg::HEADER_BYTES)) ?
                                           fill - POS_W'(rras_pkg::HEADER_BYTES) : '0;
               write_pos_in = (POS_W'(res_size) >= cfg.cap) ? '0 : POS_W'(res_size);
               used_in      = used_fill[POS_W-1:0];
            end else begin
               result.status = rras_pkg::STATUS_DROPPED;
               if (lost_ff != '1) begin
                  lost_in = lost_ff + LOST_W'(1);
               end
               result.lost_count = lost_in;
            end
         end
         rras_pkg::CMD_RELEASE: begin
            if (POS_W'(rel_size) > used_ff) begin
               result.status = rras_pkg::STATUS_REJECTED;
            end else begin
               used_in     = used_ff - POS_W'(rel_size);
               read_pos_in = rpos_wrap;
            end
         end
         rras_pkg::CMD_READ_LOST: begin
            lost_in = '0;
         end
         default: begin
         end
      endcase
      result.bytes_used   = used_in;
      result.write_offset = write_pos_in;
      result.read_offset  = read_pos_in;
      result.empty_res    = (used_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset || cfg.clear) begin
         write_pos_ff <= '0;
         read_pos_ff  <= '0;
         used_ff      <= '0;
         lost_ff      <= '0;
      end else if (fire) begin
         write_pos_ff <= write_pos_in;
         read_pos_ff  <= read_pos_in;
         used_ff      <= used_in;
         lost_ff      <= lost_in;
      end
   end

endmodule

FILE: rtl/record_ring_space_allocator.sv
// a request waits in the input register, then its result is registered in the output register
// throughput: one request per cycle while rsp_stall is low; the pointer and byte-count update is one register step
// while a result waits one more request is taken into the input register, then req_stall
// follows rsp_stall until the waiting result is taken
// reset (synchronous, active high): empty ring, lost count zero, ring_bytes 307200,
// contiguous mode off
module record_ring_space_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rras_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rras_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rras_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rras_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rras_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   rras_pkg::cfg_type cfg;
   rras_pkg::req_type in_ff;
   rras_pkg::req_type in_in;
   logic              in_vld_ff;
   logic              in_vld_in;
   rras_pkg::rsp_type out_ff;
   rras_pkg::rsp_type out_in;
   logic              out_vld_ff;
   logic              out_vld_in;
   rras_pkg::rsp_type result;
   logic              fire;
   logic              req_take;
   logic              rsp_take;

   rras_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rras_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (in_ff),
      .result (result)
   );

   assign rsp_take  = out_vld_ff && !rsp_stall;
   assign fire      = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_in      = in_ff;
      in_vld_in  = in_vld_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      if (fire) begin
         in_vld_in = 1'b0;
      end
      if (req_take) begin
         in_in     = req_data;
         in_vld_in = 1'b1;
      end
      if (rsp_take) begin
         out_vld_in = 1'b0;
      end
      if (fire) begin
         out_in     = result;
         out_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed request did not reach the result register");

   a_drop_has_no_place: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == rras_pkg::STATUS_DROPPED |->
         rsp_data.record_offset == '0 && !rsp_data.filler_written)
      else $error("dropped reserve reports a placement");

   a_used_within_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.bytes_used <= cfg.cap)
      else $error("bytes in use exceed ring capacity");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.empty_res == (rsp_data.bytes_used == '0))
      else $error("empty flag disagrees with bytes in use");

endmodule

FILE: verif/record_ring_space_allocator_test.sv
`timescale 1ns / 1ps

module record_ring_space_allocator_test;
   import rras_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_AT = 700;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned CALM_FROM = 300;
   localparam int unsigned CALM_TO = 600;

   typedef enum bit {ROW_REQUEST, ROW_WRITE} row_kind_e;

   typedef struct {
      row_kind_e                 kind;
      req_type                   request;
      logic [CSR_ADDR_W-1:0]     addr;
      logic [CSR_DATA_W-1:0]     value;
      bit                        typed;
      rsp_type                   result;
   } script_row_t;

   typedef struct {
      int unsigned ring;
      int unsigned contig;
      int unsigned count;
      int unsigned reserve_pct;
   } phase_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // allocator state as the predictor sees it
   int unsigned ring_reg = RING_RESET;
   int unsigned contig_reg = 0;
   int unsigned wr_pos = 0;
   int unsigned rd_pos = 0;
   int unsigned used = 0;
   int unsigned lost = 0;

   // byte chunks still held in the ring, oldest first
   int unsigned held_q[$];
   rsp_type     expected_q[$];

   bit          failed = 1'b0;
   int unsigned sent_count = 0;
   int unsigned rsp_seen = 0;
   int unsigned hold_left = 0;
   bit          held = 1'b0;
   int unsigned quiet_cycles = 0;

   record_ring_space_allocator uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic int unsigned ring_cap();
      return (ring_reg / ALIGN_BYTES) * ALIGN_BYTES;
   endfunction

   function automatic int unsigned rec_bytes(int unsigned payload);
      return ((payload + HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   endfunction

   function automatic int unsigned ring_advance(int unsigned pos, int unsigned add,
                                                int unsigned cap);
      int unsigned s;
      s = pos + add;
      if (s >= cap) s -= cap;
      if (s >= cap) s = 0;
      return s;
   endfunction

   function automatic rsp_type predict_step(req_type r);
      rsp_type     o;
      int unsigned cap;
      int unsigned lim;
      int unsigned len;
      int unsigned size;
      int unsigned fill;
      bit          placed;
      o = '0;
      cap = ring_cap();
      len = r.payload_len;
      placed = 1'b0;
      case (r.command)
         CMD_RESERVE: begin
            lim = cap / CLAMP_DIVISOR;
            if (len >= lim) len = lim;
            o.stored_len = LEN_W'(len);
            size = rec_bytes(len);
            if (used + size <= cap) begin
               if (contig_reg == 0 || wr_pos + size <= cap) begin
                  o.record_offset = POS_W'(wr_pos);
                  used += size;
                  wr_pos = ring_advance(wr_pos, size, cap);
                  placed = 1'b1;
               end else begin
                  fill = cap - wr_pos;
                  if (used + size + fill <= cap) begin
                     o.filler_written = 1'b1;
                     o.filler_offset = POS_W'(wr_pos);
                     o.filler_payload_len = fill > HEADER_BYTES ?
                                            POS_W'(fill - HEADER_BYTES) : '0;
                     wr_pos = size >= cap ? 0 : size;
                     used += size + fill;
                     placed = 1'b1;
                  end
               end
            end
            if (!placed) begin
               o.status = STATUS_DROPPED;
               if (lost != 32'hFFFF_FFFF) lost++;
            end
            o.lost_count = lost;
         end
         CMD_RELEASE: begin
            size = rec_bytes(len);
            if (size > used) begin
               o.status = STATUS_REJECTED;
            end else begin
               used -= size;
               rd_pos = ring_advance(rd_pos, size, cap);
            end
            o.lost_count = lost;
         end
         CMD_READ_LOST: begin
            o.lost_count = lost;
            lost = 0;
         end
         default: begin
            o.lost_count = lost;
         end
      endcase
      o.bytes_used = POS_W'(used);
      o.write_offset = POS_W'(wr_pos);
      o.read_offset = POS_W'(rd_pos);
      o.empty_res = (used == 0);
      return o;
   endfunction

   function automatic void note_placement(req_type r, rsp_type got);
      int unsigned n;
      if (r.command == CMD_RESERVE && got.status == STATUS_OK) begin
         if (got.filler_written) held_q.push_back(ring_cap() - got.filler_offset);
         held_q.push_back(rec_bytes(got.stored_len));
      end else if (r.command == CMD_RELEASE && got.status == STATUS_OK) begin
         n = rec_bytes(r.payload_len);
         while (n > 0 && held_q.size() > 0) begin
            if (held_q[0] <= n) begin
               n -= held_q[0];
               void'(held_q.pop_front());
            end else begin
               held_q[0] -= n;
               n = 0;
            end
         end
      end
   endfunction

   function automatic rsp_type expect_rsp(logic [STATUS_W-1:0] status, int unsigned rec,
                                          int unsigned stored, int unsigned bytes,
                                          int unsigned wp, int unsigned rp,
                                          int unsigned lost_val);
      rsp_type o;
      o = '0;
      o.status = status;
      o.record_offset = POS_W'(rec);
      o.stored_len = LEN_W'(stored);
      o.bytes_used = POS_W'(bytes);
      o.write_offset = POS_W'(wp);
      o.read_offset = POS_W'(rp);
      o.lost_count = lost_val;
      o.empty_res = (bytes == 0);
      return o;
   endfunction

   function automatic script_row_t step_row(logic [CMD_W-1:0] cmd, logic [LEN_W-1:0] len);
      script_row_t row;
      row = '{ROW_REQUEST, '{command: cmd, payload_len: len}, '0, '0, 1'b0, '0};
      return row;
   endfunction

   function automatic script_row_t checked_row(logic [CMD_W-1:0] cmd,
                                               logic [LEN_W-1:0] len, rsp_type res);
      script_row_t row;
      row = '{ROW_REQUEST, '{command: cmd, payload_len: len}, '0, '0, 1'b1, res};
      return row;
   endfunction

   function automatic script_row_t write_row(logic [CSR_ADDR_W-1:0] addr,
                                             logic [CSR_DATA_W-1:0] value);
      script_row_t row;
      row = '{ROW_WRITE, '0, addr, value, 1'b0, '0};
      return row;
   endfunction

   // mostly well-formed traffic: reserves and releases of the head chunk
   function automatic req_type next_request(int unsigned reserve_pct);
      req_type     r;
      int unsigned roll;
      int unsigned hi;
      int unsigned chunk;
      roll = $urandom_range(99);
      if (roll < 6) begin
         r.command = CMD_W'($urandom_range(3));
         r.payload_len = LEN_W'($urandom_range(65535));
      end else if (roll < 9) begin
         r.command = CMD_READ_LOST;
         r.payload_len = LEN_W'($urandom_range(65535));
      end else if ($urandom_range(99) < reserve_pct) begin
         r.command = CMD_RESERVE;
         case ($urandom_range(2))
            0: r.payload_len = LEN_W'($urandom_range(255));
            1: begin
               hi = ring_cap() / CLAMP_DIVISOR + 64;
               if (hi > 65535) hi = 65535;
               r.payload_len = LEN_W'($urandom_range(hi));
            end
            default: r.payload_len = LEN_W'($urandom_range(65535));
         endcase
      end else begin
         r.command = CMD_RELEASE;
         if (held_q.size() == 0) begin
            r.payload_len = LEN_W'($urandom_range(65535));
         end else begin
            chunk = held_q[0];
            r.payload_len = chunk > 65536 ? LEN_W'(65504) : LEN_W'(chunk - HEADER_BYTES);
         end
      end
      return r;
   endfunction

   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_result);
      rsp_type got;
      if (sent_count < CALM_FROM || sent_count >= CALM_TO)
         while ($urandom_range(99) < 20) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sent_count++;
      got = predict_step(r);
      note_placement(r, got);
      expected_q.push_back(typed ? typed_result : got);
   endtask

   task automatic settle_idle();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_RING_BYTES) begin
         ring_reg = value[POS_W-1:0];
         wr_pos = 0;
         rd_pos = 0;
         used = 0;
         lost = 0;
         held_q.delete();
      end else if (addr == ADDR_CONTIGUOUS) begin
         contig_reg = value[0];
      end
      @(posedge clock);
   endtask

   task automatic note_field(input string name, input logic [63:0] want,
                             input logic [63:0] seen);
      if (want !== seen) begin
         $error("%s: expected %0d, actual %0d", name, want, seen);
         failed = 1'b1;
      end
   endtask

   task automatic compare_result(input rsp_type want, input rsp_type seen);
      note_field("status", want.status, seen.status);
      note_field("record_offset", want.record_offset, seen.record_offset);
      note_field("stored_len", want.stored_len, seen.stored_len);
      note_field("filler_written", want.filler_written, seen.filler_written);
      note_field("filler_offset", want.filler_offset, seen.filler_offset);
      note_field("filler_payload_len", want.filler_payload_len, seen.filler_payload_len);
      note_field("bytes_used", want.bytes_used, seen.bytes_used);
      note_field("write_offset", want.write_offset, seen.write_offset);
      note_field("read_offset", want.read_offset, seen.read_offset);
      note_field("lost_count", want.lost_count, seen.lost_count);
      note_field("empty_res", want.empty_res, seen.empty_res);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("result with no request outstanding");
            failed = 1'b1;
         end else begin
            compare_result(expected_q.pop_front(), rsp_data);
         end
      end
   end

   // result side: random stalls, one calm stretch and one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) rsp_seen <= rsp_seen + 1;
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (rsp_seen == HOLD_AT && !held) begin
            held <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (rsp_seen >= CALM_FROM && rsp_seen < CALM_TO) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 20);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      script_row_t script[$];
      phase_t      phases[8];
      rsp_type     none;
      none = '0;

      // reset ring: empty handling, clamp to a fifth, drop when full
      script.push_back(checked_row(CMD_RELEASE, 16'd0,
                       expect_rsp(STATUS_REJECTED, 0, 0, 0, 0, 0, 0)));
      script.push_back(checked_row(CMD_READ_LOST, 16'hFFFF,
                       expect_rsp(STATUS_OK, 0, 0, 0, 0, 0, 0)));
      script.push_back(checked_row(CMD_RESERVE, 16'd0,
                       expect_rsp(STATUS_OK, 0, 0, 32, 32, 0, 0)));
      script.push_back(checked_row(CMD_RESERVE, 16'hFFFF,
                       expect_rsp(STATUS_OK, 32, 61440, 61504, 61504, 0, 0)));
      script.push_back(step_row(CMD_RESERVE, 16'd61440));
      script.push_back(step_row(CMD_RELEASE, 16'd0));
      script.push_back(step_row(CMD_UNUSED, 16'hFFFF));
      script.push_back(step_row(CMD_RESERVE, 16'hFFFF));
      script.push_back(step_row(CMD_RESERVE, 16'hFFFF));
      script.push_back(step_row(CMD_RESERVE, 16'hFFFF));
      script.push_back(step_row(CMD_RELEASE, 16'hFFFF));
      script.push_back(step_row(CMD_READ_LOST, 16'd0));
      // contiguous: a header-sized filler at the ring end, then a drop
      script.push_back(write_row(ADDR_RING_BYTES, 32'd8192));
      script.push_back(write_row(ADDR_CONTIGUOUS, 32'd1));
      script.push_back(step_row(CMD_RESERVE, 16'd1638));
      script.push_back(step_row(CMD_RESERVE, 16'd1638));
      script.push_back(step_row(CMD_RESERVE, 16'd1638));
      script.push_back(step_row(CMD_RESERVE, 16'd1638));
      script.push_back(step_row(CMD_RESERVE, 16'd1344));
      script.push_back(step_row(CMD_RELEASE, 16'd1638));
      script.push_back(step_row(CMD_RESERVE, 16'd1));
      script.push_back(step_row(CMD_RESERVE, 16'd1638));
      // zero-sized ring
      script.push_back(write_row(ADDR_RING_BYTES, 32'd0));
      script.push_back(checked_row(CMD_RESERVE, 16'd0,
                       expect_rsp(STATUS_DROPPED, 0, 0, 0, 0, 0, 1)));
      script.push_back(checked_row(CMD_RELEASE, 16'd0,
                       expect_rsp(STATUS_REJECTED, 0, 0, 0, 0, 0, 1)));

      phases[0] = '{8192, 1, 300, 55};
      phases[1] = '{1228800, 0, 250, 55};
      phases[2] = '{2097151, 1, 250, 60};
      phases[3] = '{$urandom_range(1228800, 8192), $urandom_range(1), 250, 55};
      phases[4] = '{8192, 0, 250, 50};
      phases[5] = '{0, 1, 40, 50};
      phases[6] = '{$urandom_range(16384, 8192), 1, 250, 55};
      phases[7] = '{RING_RESET, 1, 250, 55};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == ROW_WRITE) begin
            req_valid <= 1'b0;
            settle_idle();
            write_csr(script[i].addr, script[i].value);
         end else begin
            send_request(script[i].request, script[i].typed, script[i].result);
         end
      end

      foreach (phases[p]) begin
         req_valid <= 1'b0;
         settle_idle();
         write_csr(ADDR_RING_BYTES, phases[p].ring);
         write_csr(ADDR_CONTIGUOUS, phases[p].contig);
         repeat (phases[p].count) send_request(next_request(phases[p].reserve_pct), 1'b0, none);
      end

      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (!failed)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: sim.f
rtl/rras_pkg.sv
rtl/rras_csr.sv
rtl/rras_engine.sv
rtl/record_ring_space_allocator.sv
verif/record_ring_space_allocator_test.sv
